>>> rtl/irc_message_tokenizer_core_defines.svh
// Assertion macros shared by the tokenizer checker.
`ifndef IRC_MESSAGE_TOKENIZER_CORE_DEFINES_SVH
`define IRC_MESSAGE_TOKENIZER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define IRC_TOK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tokenizer check failed");

// Clocked assertion that also holds while reset is high.
`define IRC_TOK_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tokenizer reset check failed");

`endif

>>> rtl/irc_tok_pkg.sv
// Types, constants and helper functions for the IRC message tokenizer.
package irc_tok_pkg;

  // Highest parameter count supported by the protocol handling.
  localparam int MAX_PARAMS = 16;
  localparam int LIMIT_INT  = (MAX_PARAMS - 1 > 15) ? 15 : MAX_PARAMS - 1;
  localparam logic [3:0] INDEX_LIMIT = LIMIT_INT[3:0];

  // Special characters.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Byte classes reported on the result.
  localparam logic [2:0] KIND_SEP    = 3'd0;
  localparam logic [2:0] KIND_PREFIX = 3'd1;
  localparam logic [2:0] KIND_CMD    = 3'd2;
  localparam logic [2:0] KIND_MID    = 3'd3;
  localparam logic [2:0] KIND_TRAIL  = 3'd4;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_PFX   = 3'd1,
    PH_CSKIP = 3'd2,
    PH_CMD   = 3'd3,
    PH_PSKIP = 3'd4,
    PH_MID   = 3'd5,
    PH_TRAIL = 3'd6
  } phase_t;

  // One classified byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic [3:0] param_index;
    logic       token_first;
    logic       msg_end;
    logic       msg_error;
  } result_t;

  // Map a-z to A-Z, leave every other byte alone.
  function automatic logic [7:0] upper_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

>>> rtl/irc_tok_in_stage.sv
// Input register stage of the tokenizer: captures one beat from the slave side.
module irc_tok_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  input  logic       down_ready,
  output logic       valid,
  output logic [7:0] in_byte,
  output logic       in_last
);

  // The stage can load whenever it is empty or its beat moves on this cycle.
  assign s_axis_tready = !valid || down_ready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

endmodule

>>> rtl/irc_tok_fsm.sv
// Parser state and byte classification of the tokenizer.
module irc_tok_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output irc_tok_pkg::result_t res
);

  irc_tok_pkg::phase_t phase, phase_next;
  logic [3:0]          param_count, param_count_next;

  // State registers advance once per byte taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= irc_tok_pkg::PH_LEAD;
      param_count <= 4'd0;
    end else if (step) begin
      phase       <= phase_next;
      param_count <= param_count_next;
    end
  end

  // Classification of the current byte and next state.
  always_comb begin
    logic                sp;
    irc_tok_pkg::phase_t ph;
    sp               = (in_byte == irc_tok_pkg::CH_SPACE);
    ph               = phase;
    param_count_next = param_count;
    res.out_byte     = in_byte;
    res.kind         = irc_tok_pkg::KIND_SEP;
    res.param_index  = 4'd0;
    res.token_first  = 1'b0;
    res.msg_end      = in_last;
    res.msg_error    = 1'b0;

    unique case (phase)
      irc_tok_pkg::PH_PFX: begin
        if (sp) begin
          ph = irc_tok_pkg::PH_CSKIP;
        end else begin
          res.kind = irc_tok_pkg::KIND_PREFIX;
        end
      end
      irc_tok_pkg::PH_CMD: begin
        if (sp) begin
          ph = irc_tok_pkg::PH_PSKIP;
        end else begin
          res.kind     = irc_tok_pkg::KIND_CMD;
          res.out_byte = irc_tok_pkg::upper_byte(in_byte);
        end
      end
      irc_tok_pkg::PH_PSKIP: begin
        if (sp) begin
          res.kind = irc_tok_pkg::KIND_SEP;
        end else if (in_byte == irc_tok_pkg::CH_COLON) begin
          res.token_first = 1'b1;
          ph              = irc_tok_pkg::PH_TRAIL;
        end else begin
          res.kind        = irc_tok_pkg::KIND_MID;
          res.token_first = 1'b1;
          res.param_index = param_count;
          ph              = irc_tok_pkg::PH_MID;
        end
      end
      irc_tok_pkg::PH_MID: begin
        if (sp) begin
          if (param_count < irc_tok_pkg::INDEX_LIMIT) begin
            param_count_next = param_count + 4'd1;
          end
          ph = irc_tok_pkg::PH_PSKIP;
        end else begin
          res.kind        = irc_tok_pkg::KIND_MID;
          res.param_index = param_count;
        end
      end
      irc_tok_pkg::PH_TRAIL: begin
        res.kind = irc_tok_pkg::KIND_TRAIL;
      end
      default: begin
        // Leading skip, skip before the command, and the unused code.
        if (sp) begin
          res.kind = irc_tok_pkg::KIND_SEP;
        end else if (phase != irc_tok_pkg::PH_CSKIP &&
                     in_byte == irc_tok_pkg::CH_COLON) begin
          res.token_first = 1'b1;
          ph              = irc_tok_pkg::PH_PFX;
        end else begin
          res.kind        = irc_tok_pkg::KIND_CMD;
          res.token_first = 1'b1;
          res.out_byte    = irc_tok_pkg::upper_byte(in_byte);
          ph              = irc_tok_pkg::PH_CMD;
        end
      end
    endcase

    // At the end of a message, check that a command was seen and rewind.
    if (in_last) begin
      res.msg_error    = (ph == irc_tok_pkg::PH_LEAD) || (ph == irc_tok_pkg::PH_PFX) ||
                         (ph == irc_tok_pkg::PH_CSKIP);
      phase_next       = irc_tok_pkg::PH_LEAD;
      param_count_next = 4'd0;
    end else begin
      phase_next = ph;
    end
  end

endmodule

>>> rtl/irc_message_tokenizer_core.sv
// An accepted byte is held in the input register, classified by the parser and then
// offered from the result register. Throughput: one byte per cycle while the master side
// accepts; the input and result registers each hold one beat, parser state moves per byte.
// Reset: synchronous, active high; both stages empty, parser back to leading-space skip
// with the parameter count at zero.
// Top level of the IRC message tokenizer.
module irc_message_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] param_index, rest zero
  output logic        m_axis_tlast,   // msg_end
  output logic [4:0]  m_axis_tuser    // [2:0] kind, [3] token_first, [4] msg_error
);

  logic                 down_ready;
  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 in_last;
  logic                 step;
  irc_tok_pkg::result_t res;
  irc_tok_pkg::result_t out_res;

  // The result register frees up when empty or when its beat is taken.
  assign down_ready = !m_axis_tvalid || m_axis_tready;
  assign step       = in_valid && down_ready;

  irc_tok_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .down_ready    (down_ready),
    .valid         (in_valid),
    .in_byte       (in_byte),
    .in_last       (in_last)
  );

  irc_tok_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  // Result register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (down_ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  // Pack the result beat.
  assign m_axis_tdata = {4'd0, out_res.param_index, out_res.out_byte};
  assign m_axis_tlast = out_res.msg_end;
  assign m_axis_tuser = {out_res.msg_error, out_res.token_first, out_res.kind};

endmodule

>>> rtl/irc_tok_checker.sv
// Port-level checker for the IRC message tokenizer, bound to the top level.
`include "irc_message_tokenizer_core_defines.svh"

module irc_tok_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [4:0]  m_axis_tuser
);

  logic        non_mid;
  logic        marker;
  logic        stalled;
  logic [21:0] out_beat;

  // Views of the result beat used by the checks below.
  assign non_mid  = m_axis_tvalid && (m_axis_tuser[2:0] != irc_tok_pkg::KIND_MID);
  assign marker   = m_axis_tvalid && m_axis_tuser[3] &&
                    (m_axis_tuser[2:0] == irc_tok_pkg::KIND_SEP);
  assign stalled  = m_axis_tvalid && !m_axis_tready;
  assign out_beat = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // Nothing is offered straight after reset.
  `IRC_TOK_ASSERT_RST(a_empty_after_reset, rst |=> !m_axis_tvalid)

  // An error flag only comes with the last beat of a message.
  `IRC_TOK_ASSERT(a_error_on_last, (m_axis_tvalid && m_axis_tuser[4]) |-> m_axis_tlast)

  // The parameter index is zero outside middle parameters.
  `IRC_TOK_ASSERT(a_index_only_mid, non_mid |-> (m_axis_tdata[11:8] == 4'd0))

  // A token start with separator class is always the colon marker.
  `IRC_TOK_ASSERT(a_marker_is_colon, marker |-> (m_axis_tdata[7:0] == irc_tok_pkg::CH_COLON))

  // A stalled beat holds its payload.
  `IRC_TOK_ASSERT(a_hold_on_stall, stalled |=> (m_axis_tvalid && $stable(out_beat)))

endmodule

bind irc_message_tokenizer_core irc_tok_checker u_irc_tok_checker (.*);
